@@ hw/rtl/tno_pkg.sv @@
// telnet option negotiator: shared types and protocol constants
// used by telnet_option_negotiator; no dependencies

package tno_pkg;

  // request codes on the input word
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_OPEN = 2'd1;
  localparam logic [1:0] REQ_LOST = 2'd2;

  // telnet bytes
  localparam logic [7:0] IAC_BYTE = 8'hFF;
  localparam logic [7:0] CMD_WILL = 8'hFB;
  localparam logic [7:0] CMD_WONT = 8'hFC;
  localparam logic [7:0] CMD_DO   = 8'hFD;
  localparam logic [7:0] CMD_DONT = 8'hFE;
  localparam logic [7:0] OPT_SGA  = 8'h03;
  localparam logic [7:0] OPT_ECHO = 8'h01;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] NO_REPLY = 8'h00;

  // destinations
  localparam logic DEST_RX   = 1'b0;
  localparam logic DEST_PEER = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_IAC  = 4'b0100,
    PH_CMD  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_dest;
    logic       last_of_run;
  } out_word_t;

endpackage

@@ hw/rtl/telnet_option_negotiator.sv @@
// telnet option negotiator top level: escape decoding and reply generation
// depends on tno_pkg

// Usage
// in channel: one word per event (byte received, connection opened,
// connection lost); taken when in_valid_i is high and in_stall_o is low.
// out channel: bytes for the receive queue (out_dest 0) or reply bytes for
// the peer (out_dest 1); last_of_run marks the final word of one event.
// An event is held in an input register and decoded there against the
// connection state; its words then go to a run register that emits them
// one per cycle while out_stall_i is low. The first result word is offered
// once the event has been loaded from the input register into the run
// register. Events that give one word or none flow at one per cycle while
// out_stall_i is low; an IAC command option triple that draws a reply gives
// three words and so holds the run register until all three are taken.
// Reset: no connection, nothing pending, both valids low.
// When the receiver stalls, the current word holds; events that give no
// word are still taken, and once one that gives words sits in the input
// register, in_stall_o rises until the run register can take its words.
module telnet_option_negotiator
  import tno_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic      in_vld_q, in_vld_d;
  in_word_t  in_q;
  phase_e    phase_q, phase_d;
  logic      pnull_q, pnull_d;
  logic [7:0] pcmd_q, pcmd_d;

  logic [1:0] run_cnt_q, run_cnt_d;
  logic       run_reply_q;
  logic [7:0] run_byte_q;
  logic [7:0] run_opt_q;

  logic [1:0] dec_cnt;
  logic       dec_reply;
  logic [7:0] dec_byte;
  logic [7:0] reply_cmd;
  logic       load_ok;
  logic       adv;
  logic       pop;
  logic       load;

  function automatic logic [7:0] reply_of(input logic [7:0] cmd, input logic [7:0] opt);
    logic [7:0] r;
    r = NO_REPLY;
    if (cmd == CMD_WILL && opt == OPT_SGA) begin
      r = CMD_DO;
    end else if (cmd == CMD_DO && (opt == OPT_SGA || opt == OPT_ECHO)) begin
      r = CMD_WILL;
    end else if (cmd == CMD_WONT) begin
      r = CMD_DONT;
    end else if (cmd == CMD_DONT) begin
      r = CMD_WILL;
    end
    return r;
  endfunction

  assign reply_cmd = reply_of(pcmd_q, in_q.rx_byte);

  // decode the held event against the link state
  always_comb begin
    dec_cnt   = 2'd0;
    dec_reply = 1'b0;
    dec_byte  = in_q.rx_byte;
    phase_d   = phase_q;
    pnull_d   = pnull_q;
    pcmd_d    = pcmd_q;
    case (in_q.req_type)
      REQ_OPEN: begin
        if (phase_q == PH_IDLE) phase_d = PH_DATA;
      end
      REQ_LOST: begin
        phase_d = PH_IDLE;
      end
      REQ_BYTE: begin
        case (phase_q)
          PH_DATA: begin
            if (in_q.rx_byte == IAC_BYTE) begin
              phase_d = PH_IAC;
            end else if (in_q.rx_byte != NUL_BYTE || pnull_q) begin
              pnull_d = 1'b0;
              dec_cnt = 2'd1;
            end else begin
              pnull_d = 1'b1;
            end
          end
          PH_IAC: begin
            if (in_q.rx_byte == IAC_BYTE) begin
              phase_d = PH_DATA;
              dec_cnt = 2'd1;
            end else begin
              pcmd_d  = in_q.rx_byte;
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            phase_d = PH_DATA;
            if (reply_cmd != NO_REPLY) begin
              dec_cnt   = 2'd3;
              dec_reply = 1'b1;
              dec_byte  = reply_cmd;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign pop     = out_valid_o && !out_stall_i;
  assign load_ok = (run_cnt_q == 2'd0) || (run_cnt_q == 2'd1 && !out_stall_i);
  assign adv     = in_vld_q && ((dec_cnt == 2'd0) || load_ok);
  assign load    = adv && (dec_cnt != 2'd0);

  assign in_stall_o = in_vld_q && !adv;
  assign in_vld_d   = in_stall_o || in_valid_i;

  always_comb begin
    run_cnt_d = run_cnt_q;
    if (load) begin
      run_cnt_d = dec_cnt;
    end else if (pop) begin
      run_cnt_d = run_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_IDLE;
      pnull_q   <= 1'b0;
      pcmd_q    <= 8'h00;
      run_cnt_q <= 2'd0;
    end else begin
      in_vld_q  <= in_vld_d;
      run_cnt_q <= run_cnt_d;
      if (adv) begin
        phase_q <= phase_d;
        pnull_q <= pnull_d;
        pcmd_q  <= pcmd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (load) begin
      run_reply_q <= dec_reply;
      run_byte_q  <= dec_byte;
      run_opt_q   <= in_q.rx_byte;
    end
  end

  // word selection within a run
  always_comb begin
    out_data_o.out_byte    = run_byte_q;
    out_data_o.out_dest    = DEST_RX;
    out_data_o.last_of_run = (run_cnt_q == 2'd1);
    if (run_reply_q) begin
      out_data_o.out_dest = DEST_PEER;
      case (run_cnt_q)
        2'd3:    out_data_o.out_byte = IAC_BYTE;
        2'd2:    out_data_o.out_byte = run_byte_q;
        default: out_data_o.out_byte = run_opt_q;
      endcase
    end
  end

  assign out_valid_o = (run_cnt_q != 2'd0);

`ifndef ASSERT_OFF
  a_single_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_cnt_q != 2'd0 && !run_reply_q) |-> run_cnt_q == 2'd1)
    else $error("plain run longer than one word");

  a_reply_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && dec_reply) |=> (run_cnt_q == 2'd3 && out_data_o.out_byte == IAC_BYTE))
    else $error("reply run did not start with IAC");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_q)))
    else $error("held event lost or overwritten");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (run_cnt_q == 2'd0 || (run_cnt_q == 2'd1 && pop)))
    else $error("run register loaded over pending words");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench for telnet_option_negotiator: directed escapes, then random link traffic
// checked word by word against a behavioural decoder; depends on tno_pkg and the rtl

module testbench;
  import tno_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  telnet_option_negotiator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // knobs set by the test tasks
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_end = 0;

  // decoder state and the words it still owes
  phase_e      link_phase = PH_IDLE;
  logic        linked = 1'b0;
  logic        nul_held = 1'b0;
  logic [7:0]  held_cmd = '0;
  out_word_t   due_words[$];

  int faults = 0;
  int events_taken = 0;
  int words_checked = 0;
  int replies_seen = 0;
  int input_held = 0;
  int cycle_no = 0;

  function automatic logic [7:0] reply_for(logic [7:0] cmd, logic [7:0] opt);
    if (cmd == CMD_WILL && opt == OPT_SGA) return CMD_DO;
    if (cmd == CMD_DO && (opt == OPT_SGA || opt == OPT_ECHO)) return CMD_WILL;
    if (cmd == CMD_WONT) return CMD_DONT;
    if (cmd == CMD_DONT) return CMD_WILL;
    return NO_REPLY;
  endfunction

  function automatic void owe_word(logic [7:0] b, logic dest, logic last);
    out_word_t w;
    w.out_byte = b;
    w.out_dest = dest;
    w.last_of_run = last;
    due_words.push_back(w);
  endfunction

  function automatic void decode_event(in_word_t ev);
    logic [7:0] reply;
    case (ev.req_type)
      REQ_OPEN: begin
        if (!linked) begin
          linked = 1'b1;
          link_phase = PH_DATA;
        end
      end
      REQ_LOST: begin
        // nul flag and held command survive a drop
        if (linked) begin
          linked = 1'b0;
          link_phase = PH_IDLE;
        end
      end
      REQ_BYTE: begin
        if (linked) begin
          case (link_phase)
            PH_DATA: begin
              if (ev.rx_byte == IAC_BYTE) begin
                link_phase = PH_IAC;
              end else if (ev.rx_byte != NUL_BYTE || nul_held) begin
                nul_held = 1'b0;
                owe_word(ev.rx_byte, DEST_RX, 1'b1);
              end else begin
                nul_held = 1'b1;
              end
            end
            PH_IAC: begin
              if (ev.rx_byte == IAC_BYTE) begin
                link_phase = PH_DATA;
                owe_word(IAC_BYTE, DEST_RX, 1'b1);
              end else begin
                held_cmd = ev.rx_byte;
                link_phase = PH_CMD;
              end
            end
            PH_CMD: begin
              reply = reply_for(held_cmd, ev.rx_byte);
              link_phase = PH_DATA;
              if (reply != NO_REPLY) begin
                owe_word(IAC_BYTE, DEST_PEER, 1'b0);
                owe_word(reply, DEST_PEER, 1'b0);
                owe_word(ev.rx_byte, DEST_PEER, 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_fault(string what, out_word_t want, out_word_t got);
    faults++;
    if (faults <= 10)
      $display("mismatch (%s): expected byte %h dest %b last %b, got byte %h dest %b last %b",
               what, want.out_byte, want.out_dest, want.last_of_run,
               got.out_byte, got.out_dest, got.last_of_run);
  endfunction

  // receiver: random stall, or a long hold-off while cycle_no is below hold_end
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    out_stall_i <= (cycle_no < hold_end) || ($urandom_range(99) < stall_pct);
  end

  // input side feeds the decoder first, then the output word is checked
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_held++;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      events_taken++;
      decode_event(in_data_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (out_data_o.out_dest == DEST_PEER && out_data_o.last_of_run) replies_seen++;
      if (due_words.size() == 0) begin
        note_fault("unexpected word", '0, out_data_o);
      end else begin
        want = due_words.pop_front();
        if (out_data_o.out_byte !== want.out_byte ||
            out_data_o.out_dest !== want.out_dest ||
            out_data_o.last_of_run !== want.last_of_run)
          note_fault("field", want, out_data_o);
      end
    end
  end

  task automatic send_word(input logic [1:0] req, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= in_word_t'{req_type: req, rx_byte: b};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(REQ_BYTE, b);
  endtask

  task automatic send_triple(input logic [7:0] cmd, input logic [7:0] opt);
    send_byte(IAC_BYTE);
    send_byte(cmd);
    send_byte(opt);
  endtask

  // sender stops and waits for every owed word
  task automatic await_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_chunk(output int useful);
    int pick;
    logic [7:0] cmd, opt;
    pick = $urandom_range(99);
    useful = 1;
    if (pick < 40) begin
      // plain data, with nul runs now and then
      send_byte(($urandom_range(3) == 0) ? NUL_BYTE : 8'($urandom_range(254)));
    end else if (pick < 75) begin
      case ($urandom_range(4))
        0: cmd = CMD_WILL;
        1: cmd = CMD_WONT;
        2: cmd = CMD_DO;
        3: cmd = CMD_DONT;
        default: cmd = 8'($urandom);
      endcase
      case ($urandom_range(3))
        0: opt = OPT_SGA;
        1: opt = OPT_ECHO;
        2: opt = IAC_BYTE;
        default: opt = 8'($urandom);
      endcase
      send_triple(cmd, opt);
      useful = 3;
    end else if (pick < 83) begin
      send_byte(IAC_BYTE);
      send_byte(IAC_BYTE);
      useful = 2;
    end else if (pick < 90) begin
      // link drop, stray bytes while down, then reopen
      send_word(REQ_LOST, 8'($urandom));
      repeat ($urandom_range(2)) send_byte(8'($urandom));
      send_word(REQ_OPEN, 8'($urandom));
      useful = 0;
    end else begin
      case ($urandom_range(4))
        0: begin
          send_byte(IAC_BYTE);
          send_word(REQ_LOST, 8'($urandom));
          send_word(REQ_OPEN, 8'($urandom));
        end
        1: begin
          send_byte(IAC_BYTE);
          send_byte(8'($urandom));
          send_word(REQ_LOST, 8'($urandom));
          send_word(REQ_OPEN, 8'($urandom));
        end
        2: send_word(REQ_SPARE, 8'($urandom));
        3: send_word(REQ_OPEN, 8'($urandom));
        default: begin
          send_word(2'($urandom), 8'($urandom));
          send_word(REQ_OPEN, 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic run_traffic(input int quota, input int idle, input int stall);
    int sent;
    int n;
    send_idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < quota) begin
      send_random_chunk(n);
      sent += n;
    end
    await_drain();
  endtask

  task automatic test_escape_handling();
    send_word(REQ_BYTE, 8'h41);      // no link yet
    send_word(REQ_LOST, 8'h00);
    send_word(REQ_SPARE, IAC_BYTE);
    send_word(REQ_OPEN, 8'h00);
    send_word(REQ_OPEN, IAC_BYTE);   // already open
    send_byte(NUL_BYTE);             // lone nul dropped
    send_byte(NUL_BYTE);             // second one passes
    send_byte(NUL_BYTE);
    send_byte(IAC_BYTE);
    send_byte(IAC_BYTE);             // doubled iac leaves the nul flag alone
    send_byte(NUL_BYTE);
    send_triple(CMD_WILL, OPT_SGA);
    send_triple(CMD_DO, OPT_SGA);
    send_triple(CMD_DO, OPT_ECHO);
    send_triple(CMD_WONT, NUL_BYTE);
    send_triple(CMD_DONT, IAC_BYTE); // iac taken as the option
    send_triple(CMD_WILL, OPT_ECHO); // consumed silently
    send_byte(IAC_BYTE);
    send_word(REQ_LOST, 8'h7F);      // escape cut off by the drop
    send_word(REQ_OPEN, 8'h00);
    send_byte(8'hFE);
    await_drain();
  endtask

  task automatic test_idle_mix();
    run_traffic(110, 0, 0);
    run_traffic(110, 72, 0);
    run_traffic(110, 0, 72);
    run_traffic(110, 27, 27);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_receiver_hold();
    hold_end <= cycle_no + 250;
    run_traffic(60, 0, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_escape_handling();
    test_idle_mix();
    test_receiver_hold();
    await_drain();
    repeat (10) @(posedge clk_i);
    $display("summary: %0d events taken, %0d words checked, %0d negotiation replies",
             events_taken, words_checked, replies_seen);
    $display("summary: input stalled for %0d cycles, %0d faults, %0d words still owed",
             input_held, faults, due_words.size());
    if (faults == 0 && due_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
